@@ sv/rect_ovl_pkg.sv @@
// Package with the shared types and constants of the rectangle outline overlay.
`timescale 1ns / 1ps

package rect_ovl_pkg;

    // Register indexes on the configuration port (byte address is 4 * index).
    localparam logic [2:0] REG_LEFT   = 3'd0;
    localparam logic [2:0] REG_TOP    = 3'd1;
    localparam logic [2:0] REG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_HEIGHT = 3'd3;
    localparam logic [2:0] REG_HITS   = 3'd4;
    localparam logic [2:0] REG_FORMAT = 3'd5;
    localparam logic [2:0] REG_COLOR  = 3'd6;

    // Pixel format codes.
    localparam logic [1:0] FMT_GRAY   = 2'd0;
    localparam logic [1:0] FMT_YUV422 = 2'd1;
    localparam logic [1:0] FMT_RGB    = 2'd2;

    // Byte lane codes.
    localparam logic [1:0] LANE_0 = 2'd0;
    localparam logic [1:0] LANE_1 = 2'd1;
    localparam logic [1:0] LANE_2 = 2'd2;

    localparam logic [9:0]  MIN_HITS    = 10'd5;
    localparam logic [23:0] COLOR_RESET = 24'hFF_FFFF;

    // Width of the coordinate arithmetic: holds left + width + border.
    localparam int COORD_W = 12;

    typedef struct packed {
        logic [9:0]  rect_left;
        logic [9:0]  rect_top;
        logic [10:0] rect_width;
        logic [10:0] rect_height;
        logic [9:0]  hit_count;
        logic [1:0]  pixel_format;
        logic [23:0] draw_color;
    } t_cfg;

endpackage

@@ sv/rect_ovl_hit.sv @@
// Outline hit test: decides whether one byte lies on the rectangle outline.
`timescale 1ns / 1ps

module rect_ovl_hit
    import rect_ovl_pkg::*;
#(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  t_cfg       i_cfg,
    input  logic [9:0] i_pixel_col,
    input  logic [9:0] i_pixel_row,
    input  logic [1:0] i_byte_lane,
    output logic       o_hit
);

    logic [COORD_W-1:0] col, row, x, y, w, h, ext;
    logic [COORD_W-1:0] x_end, y_end;
    logic               lane_ok, enable;
    logic               in_cols, in_rows;
    logic               top_band, bot_band, left_band, right_band;

    assign col = COORD_W'(i_pixel_col);
    assign row = COORD_W'(i_pixel_row);
    assign x   = COORD_W'(i_cfg.rect_left);
    assign y   = COORD_W'(i_cfg.rect_top);
    assign w   = COORD_W'(i_cfg.rect_width);
    assign h   = COORD_W'(i_cfg.rect_height);

    // One past the last column and row of the rectangle.
    assign x_end = x + w;
    assign y_end = y + h;

    always_comb begin
        unique case (i_cfg.pixel_format)
            FMT_GRAY: begin
                lane_ok = (i_byte_lane == LANE_0);
                ext     = '0;
            end
            FMT_YUV422: begin
                lane_ok = (i_byte_lane == LANE_0) || (i_byte_lane == LANE_1);
                ext     = COORD_W'(2);
            end
            FMT_RGB: begin
                lane_ok = (i_byte_lane == LANE_0) || (i_byte_lane == LANE_1)
                       || (i_byte_lane == LANE_2);
                ext     = '0;
            end
            default: begin
                lane_ok = 1'b0;
                ext     = '0;
            end
        endcase
    end

    assign enable = lane_ok && (i_cfg.hit_count > MIN_HITS)
                 && (w != '0) && (h != '0)
                 && (x_end <= COORD_W'(FRAME_WIDTH))
                 && (y_end <= COORD_W'(FRAME_HEIGHT))
                 && (col < COORD_W'(FRAME_WIDTH))
                 && (row < COORD_W'(FRAME_HEIGHT));

    // The border bands extend outward; the offsets are added on the pixel side
    // so that nothing goes below zero.
    assign in_cols    = (col >= x) && (col < x_end);
    assign in_rows    = (row >= y) && (row < y_end);
    assign top_band   = (row + ext >= y) && (row <= y);
    assign bot_band   = (row + COORD_W'(1) >= y_end) && (row < y_end + ext);
    assign left_band  = (col + ext >= x) && (col <= x);
    assign right_band = (col + COORD_W'(1) >= x_end) && (col < x_end + ext);

    assign o_hit = enable && ((in_cols && (top_band || bot_band))
                           || (in_rows && (left_band || right_band)));

endmodule

@@ sv/rectangle_outline_overlay_unit.sv @@
// Top level of the rectangle outline overlay: register port, pipeline and output.
`timescale 1ns / 1ps

// Frame bytes enter with their pixel column, row and byte lane, and leave one
// for one, in order, with any byte on the configured rectangle's outline
// replaced by that lane's color byte. The unit takes one request per clock
// unless the output stalls. A request passes an input register, the outline
// comparisons and an output register; ready passes through combinationally.
// Registers sit on an APB-style port at byte addresses 0x00 (left), 0x04
// (top), 0x08 (width), 0x0C (height), 0x10 (hit count), 0x14 (pixel format)
// and 0x18 (color), and should be written only while no request is in flight.

module rectangle_outline_overlay_unit
    import rect_ovl_pkg::*;
#(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [9:0]  i_pixel_col,
    input  logic [9:0]  i_pixel_row,
    input  logic [1:0]  i_byte_lane,
    input  logic [7:0]  i_byte_in,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_byte_out,
    output logic        o_on_outline
);

    t_cfg        r_cfg;
    logic [2:0]  reg_idx;
    logic        cfg_write;

    logic        r_s1_valid;
    logic [9:0]  r_col, r_row;
    logic [1:0]  r_lane;
    logic [7:0]  r_byte;

    logic        r_out_valid;
    logic [7:0]  r_byte_out;
    logic        r_on_outline;

    logic        out_free, s1_advance, in_take;
    logic        hit;
    logic [7:0]  color_byte, n_byte_out;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rect_left    <= '0;
            r_cfg.rect_top     <= '0;
            r_cfg.rect_width   <= '0;
            r_cfg.rect_height  <= '0;
            r_cfg.hit_count    <= '0;
            r_cfg.pixel_format <= FMT_GRAY;
            r_cfg.draw_color   <= COLOR_RESET;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_LEFT:   r_cfg.rect_left    <= pwdata[9:0];
                REG_TOP:    r_cfg.rect_top     <= pwdata[9:0];
                REG_WIDTH:  r_cfg.rect_width   <= pwdata[10:0];
                REG_HEIGHT: r_cfg.rect_height  <= pwdata[10:0];
                REG_HITS:   r_cfg.hit_count    <= pwdata[9:0];
                REG_FORMAT: r_cfg.pixel_format <= pwdata[1:0];
                REG_COLOR:  r_cfg.draw_color   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LEFT:   prdata = 32'(r_cfg.rect_left);
            REG_TOP:    prdata = 32'(r_cfg.rect_top);
            REG_WIDTH:  prdata = 32'(r_cfg.rect_width);
            REG_HEIGHT: prdata = 32'(r_cfg.rect_height);
            REG_HITS:   prdata = 32'(r_cfg.hit_count);
            REG_FORMAT: prdata = 32'(r_cfg.pixel_format);
            REG_COLOR:  prdata = 32'(r_cfg.draw_color);
            default:    prdata = '0;
        endcase
    end

    // The output register frees up when empty or when its request is taken;
    // the input register moves forward whenever the output can accept.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_advance = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_col  <= i_pixel_col;
            r_row  <= i_pixel_row;
            r_lane <= i_byte_lane;
            r_byte <= i_byte_in;
        end
    end

    rect_ovl_hit #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_hit (
        .i_cfg       (r_cfg),
        .i_pixel_col (r_col),
        .i_pixel_row (r_row),
        .i_byte_lane (r_lane),
        .o_hit       (hit)
    );

    always_comb begin
        unique case (r_lane)
            LANE_0:  color_byte = r_cfg.draw_color[7:0];
            LANE_1:  color_byte = r_cfg.draw_color[15:8];
            LANE_2:  color_byte = r_cfg.draw_color[23:16];
            default: color_byte = r_byte;
        endcase
    end

    assign n_byte_out = hit ? color_byte : r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_byte_out   <= n_byte_out;
            r_on_outline <= hit;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_byte_out   = r_byte_out;
    assign o_on_outline = r_on_outline;

endmodule
